// ----- rtl/core/swcrc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcrc_pkg
// Shared types, constants and the CRC-8 step for the sensor word checker.
// ----------------------------------------------------------------------------
package swcrc_pkg;

   // response kinds held in the configuration register
   localparam logic [1:0] KIND_VERSION     = 2'd0;
   localparam logic [1:0] KIND_SERIAL      = 2'd1;
   localparam logic [1:0] KIND_BASELINE    = 2'd2;
   localparam logic [1:0] KIND_MEASUREMENT = 2'd3;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // score constants: offset, span and rounding half of 128/23 and 1024/11
   localparam logic [15:0] CO2_OFFSET = 16'd400;
   localparam logic [15:0] CO2_SPAN   = 16'd4600;
   localparam logic [15:0] VOC_OFFSET = 16'd50;
   localparam logic [15:0] VOC_SPAN   = 16'd275;
   localparam logic [26:0] CO2_HALF   = 27'd11;
   localparam logic [26:0] VOC_HALF   = 27'd5;

   // reciprocals: floor(p*R >> s) equals p/d for the dividend ranges used
   localparam logic [27:0] CO2_RECIP  = 28'd23342214;   // 2^29/23 rounded up
   localparam logic [27:0] VOC_RECIP  = 28'd195225787;  // 2^31/11 rounded up

   // one checked word as it travels from front to back
   typedef struct packed {
      logic [15:0] word_value;
      logic        crc_ok;
      logic [1:0]  word_index;
      logic        last_word;
      logic        frame_ok;
      logic [47:0] combined_value;
      logic        score_en;
      logic        score_voc;
   } word_rec_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      for (int k = 0; k < 8; k++) begin
         if (r[7]) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic logic [1:0] words_of_kind(input logic [1:0] kind);
      logic [1:0] n;
      case (kind)
         KIND_VERSION:  n = 2'd1;
         KIND_SERIAL:   n = 2'd3;
         KIND_BASELINE: n = 2'd2;
         default:       n = 2'd2;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sensor_word_crc_response_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_word_crc_response_checker
// Checks CRC-8 of sensor response words and scores measurement words.
// ----------------------------------------------------------------------------
// throughput: one byte beat per cycle while the queue is not full; the CRC-8 step is combinational
// results: a CRC byte beat's result is registered in the queue, the score stage,
//   the multiply stage and the output register, in that order; MSB and LSB beats give no result
// reset: synchronous; clears frame state, CRC to 0xFF, queue and pipe valids,
//   response kind to measurement; no clearing pass
module sensor_word_crc_response_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [7:0]         req_data_byte,
   input  wire                req_frame_start,
   input  wire                csr_we,
   input  wire  [1:0]         csr_wdata,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [15:0]        rsp_word_value,
   output logic               rsp_crc_ok,
   output logic [1:0]         rsp_word_index,
   output logic               rsp_last_word,
   output logic               rsp_frame_ok,
   output logic [47:0]        rsp_combined_value,
   output logic signed [23:0] rsp_air_quality
);
   import swcrc_pkg::*;

   logic         push, pop, q_full, q_not_empty;
   word_rec_type push_rec, head_rec;

   swcrc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .queue_full      (q_full),
      .push            (push),
      .rec             (push_rec)
   );

   swcrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_rec  (head_rec)
   );

   swcrc_score u_score (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (q_not_empty),
      .in_rec             (head_rec),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_word_value     (rsp_word_value),
      .rsp_crc_ok         (rsp_crc_ok),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_combined_value (rsp_combined_value),
      .rsp_air_quality    (rsp_air_quality)
   );

endmodule
`default_nettype wire

// ----- rtl/core/swcrc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcrc_front
// Byte assembler and CRC-8 check; emits one word record per CRC byte.
// ----------------------------------------------------------------------------
module swcrc_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire  [7:0]             req_data_byte,
   input  wire                    req_frame_start,
   input  wire                    csr_we,
   input  wire  [1:0]             csr_wdata,
   input  wire                    queue_full,
   output logic                   push,
   output swcrc_pkg::word_rec_type rec
);
   import swcrc_pkg::*;

   localparam logic [1:0] POS_MSB = 2'd0;
   localparam logic [1:0] POS_LSB = 2'd1;
   localparam logic [1:0] POS_CRC = 2'd2;

   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  high_ff, high_in;
   logic [7:0]  low_ff, low_in;
   logic [47:0] asm_ff, asm_in;
   logic        good_ff, good_in;

   logic        fire;
   logic [1:0]  pos_e, cnt_e;
   logic [7:0]  crc_e;
   logic [47:0] asm_e, asm_new;
   logic        good_e;
   logic [15:0] word;
   logic        ok, fok, last;

   assign req_ready = !queue_full;
   assign fire      = req_valid && req_ready;

   // frame start clears frame state before the byte is taken
   assign pos_e  = req_frame_start ? POS_MSB  : pos_ff;
   assign cnt_e  = req_frame_start ? 2'd0     : cnt_ff;
   assign crc_e  = req_frame_start ? CRC_INIT : crc_ff;
   assign asm_e  = req_frame_start ? 48'd0    : asm_ff;
   assign good_e = req_frame_start ? 1'b1     : good_ff;

   assign word = {high_ff, low_ff};
   assign ok   = (crc_e == req_data_byte);
   assign fok  = good_e && ok;
   assign last = ({1'b0, cnt_e} + 3'd1) >= {1'b0, words_of_kind(kind_ff)};

   always_comb begin
      case (cnt_e)
         2'd0:    asm_new = asm_e | {32'd0, word};
         2'd1:    asm_new = asm_e | {16'd0, word, 16'd0};
         2'd2:    asm_new = asm_e | {word, 32'd0};
         default: asm_new = asm_e;
      endcase
   end

   always_comb begin
      rec.word_value     = word;
      rec.crc_ok         = ok;
      rec.word_index     = cnt_e;
      rec.last_word      = last;
      rec.frame_ok       = fok;
      rec.combined_value = (last && kind_ff != KIND_MEASUREMENT) ? asm_new : 48'd0;
      rec.score_en       = (kind_ff == KIND_MEASUREMENT) && (cnt_e != 2'd2)
                           && (cnt_e != 2'd3);
      rec.score_voc      = (cnt_e == 2'd1);
   end

   always_comb begin
      kind_in = csr_we ? csr_wdata : kind_ff;
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      crc_in  = crc_ff;
      high_in = high_ff;
      low_in  = low_ff;
      asm_in  = asm_ff;
      good_in = good_ff;
      push    = 1'b0;
      if (fire) begin
         cnt_in  = cnt_e;
         asm_in  = asm_e;
         good_in = good_e;
         case (pos_e)
            POS_MSB: begin
               high_in = req_data_byte;
               crc_in  = crc8_update(crc_e, req_data_byte);
               pos_in  = POS_LSB;
            end
            POS_LSB: begin
               low_in = req_data_byte;
               crc_in = crc8_update(crc_e, req_data_byte);
               pos_in = POS_CRC;
            end
            default: begin
               push   = 1'b1;
               pos_in = POS_MSB;
               crc_in = CRC_INIT;
               if (last) begin
                  cnt_in  = 2'd0;
                  asm_in  = 48'd0;
                  good_in = 1'b1;
               end else begin
                  cnt_in  = cnt_e + 2'd1;
                  asm_in  = asm_new;
                  good_in = fok;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_MEASUREMENT;
         pos_ff  <= POS_MSB;
         cnt_ff  <= 2'd0;
         crc_ff  <= CRC_INIT;
         asm_ff  <= 48'd0;
         good_ff <= 1'b1;
      end else begin
         kind_ff <= kind_in;
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
         crc_ff  <= crc_in;
         asm_ff  <= asm_in;
         good_ff <= good_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
      low_ff  <= low_in;
   end

   a_msb_then_lsb: assert property (@(posedge clock) disable iff (reset)
      fire && pos_e == POS_MSB |=> pos_ff == POS_LSB)
      else $error("msb beat did not advance to lsb");

   a_word_rearms_crc: assert property (@(posedge clock) disable iff (reset)
      push |=> pos_ff == POS_MSB && crc_ff == CRC_INIT)
      else $error("crc not re-armed after word");

   a_last_clears_frame: assert property (@(posedge clock) disable iff (reset)
      push && rec.last_word |=> cnt_ff == 2'd0 && good_ff && asm_ff == 48'd0)
      else $error("frame state not cleared after last word");

endmodule
`default_nettype wire

// ----- rtl/core/swcrc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcrc_queue
// Two-entry queue of word records between the front and back parts.
// ----------------------------------------------------------------------------
module swcrc_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  swcrc_pkg::word_rec_type push_rec,
   input  wire                     pop,
   output logic                    full,
   output logic                    not_empty,
   output swcrc_pkg::word_rec_type head_rec
);
   import swcrc_pkg::*;

   word_rec_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_rec  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = push   ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/swcrc_score.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcrc_score
// Back part: air-quality score pipeline and result output register.
// ----------------------------------------------------------------------------
module swcrc_score (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   input  swcrc_pkg::word_rec_type in_rec,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic [15:0]             rsp_word_value,
   output logic                    rsp_crc_ok,
   output logic [1:0]              rsp_word_index,
   output logic                    rsp_last_word,
   output logic                    rsp_frame_ok,
   output logic [47:0]             rsp_combined_value,
   output logic signed [23:0]      rsp_air_quality
);
   import swcrc_pkg::*;

   typedef struct packed {
      word_rec_type rec;
      logic         neg;
      logic [26:0]  dividend;
   } stage_a_type;

   typedef struct packed {
      word_rec_type rec;
      logic         neg;
      logic [54:0]  prod;
   } stage_b_type;

   typedef struct packed {
      word_rec_type       rec;
      logic signed [23:0] aq;
   } stage_c_type;

   logic        advance;
   logic        a_valid_ff, b_valid_ff, c_valid_ff;
   stage_a_type a_ff, a_in;
   stage_b_type b_ff, b_in;
   stage_c_type c_ff, c_in;

   logic [15:0]        offset, span, dev;
   logic signed [17:0] diff;
   logic [17:0]        mag;
   logic [27:0]        recip;
   logic [22:0]        quot;

   // whole pipe holds while the output beat waits
   assign advance = !c_valid_ff || rsp_ready;
   assign pop     = advance && in_valid;

   // stage a: |span - max(0, w - offset)| scaled, plus rounding half
   always_comb begin
      offset = in_rec.score_voc ? VOC_OFFSET : CO2_OFFSET;
      span   = in_rec.score_voc ? VOC_SPAN   : CO2_SPAN;
      dev    = (in_rec.word_value > offset) ? (in_rec.word_value - offset) : 16'd0;
      diff   = $signed({2'b00, span}) - $signed({2'b00, dev});
      mag    = diff[17] ? (18'd0 - diff) : diff;
      a_in.rec = in_rec;
      a_in.neg = diff[17];
      if (!in_rec.score_en) begin
         a_in.dividend = 27'd0;
      end else if (in_rec.score_voc) begin
         a_in.dividend = {mag[16:0], 10'd0} + VOC_HALF;
      end else begin
         a_in.dividend = {3'd0, mag[16:0], 7'd0} + CO2_HALF;
      end
   end

   // stage b: reciprocal multiply
   always_comb begin
      recip     = a_ff.rec.score_voc ? VOC_RECIP : CO2_RECIP;
      b_in.rec  = a_ff.rec;
      b_in.neg  = a_ff.neg;
      b_in.prod = {28'd0, a_ff.dividend} * {27'd0, recip};
   end

   // stage c: shift out the quotient and apply the sign
   always_comb begin
      quot     = b_ff.rec.score_voc ? b_ff.prod[53:31] : b_ff.prod[51:29];
      c_in.rec = b_ff.rec;
      if (!b_ff.rec.score_en) begin
         c_in.aq = 24'sd0;
      end else if (b_ff.neg) begin
         c_in.aq = $signed(24'd0 - {1'b0, quot});
      end else begin
         c_in.aq = $signed({1'b0, quot});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   assign rsp_valid          = c_valid_ff;
   assign rsp_word_value     = c_ff.rec.word_value;
   assign rsp_crc_ok         = c_ff.rec.crc_ok;
   assign rsp_word_index     = c_ff.rec.word_index;
   assign rsp_last_word      = c_ff.rec.last_word;
   assign rsp_frame_ok       = c_ff.rec.frame_ok;
   assign rsp_combined_value = c_ff.rec.combined_value;
   assign rsp_air_quality    = c_ff.aq;

endmodule
`default_nettype wire

// ----- tb/sv/sensor_word_crc_response_checker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_word_crc_response_checker_tb
// Feeds sensor response bytes through the word checker and compares every
// result beat with a local CRC-8 and score predictor. A short directed run
// covers the field extremes, bad CRCs and a kind change in mid-frame. Eight
// random phases follow, one per kind and then four of random kind; idle
// gaps and stalls on both channels bar the fifth; one long receiver hold-off.
// ----------------------------------------------------------------------------
module sensor_word_crc_response_checker_tb;
   import swcrc_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int DRAIN_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 175;
   localparam int HOLD_AT_BEAT  = 300;
   localparam int HOLD_CYCLES   = 600;
   localparam int PRINT_LIMIT   = 100;

   typedef struct {
      logic [7:0] data;
      logic       start;
   } sensor_beat_type;

   typedef struct {
      logic [15:0] word_value;
      logic        crc_ok;
      logic [1:0]  word_index;
      logic        last_word;
      logic        frame_ok;
      logic [47:0] combined_value;
      logic [23:0] air_quality;
   } checked_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   wire                req_ready;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_frame_start = 1'b0;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_wdata = 2'd0;
   wire                rsp_valid;
   logic               rsp_ready = 1'b0;
   wire [15:0]         rsp_word_value;
   wire                rsp_crc_ok;
   wire [1:0]          rsp_word_index;
   wire                rsp_last_word;
   wire                rsp_frame_ok;
   wire [47:0]         rsp_combined_value;
   wire signed [23:0]  rsp_air_quality;

   sensor_word_crc_response_checker dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_frame_start    (req_frame_start),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_word_value     (rsp_word_value),
      .rsp_crc_ok         (rsp_crc_ok),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_combined_value (rsp_combined_value),
      .rsp_air_quality    (rsp_air_quality)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   sensor_beat_type  beat_queue[$];
   checked_word_type expected_words[$];
   checked_word_type got_expected;

   int  error_count    = 0;
   int  beats_accepted = 0;
   int  items_pushed   = 0;
   int  cycle_count    = 0;
   int  send_gap       = 0;
   int  recv_stall     = 0;
   bit  idle_on        = 1'b1;
   logic hold_off      = 1'b0;

   // predictor state
   logic [1:0]  kind_model = KIND_MEASUREMENT;
   logic [1:0]  byte_pos;
   logic [1:0]  word_count;
   logic [7:0]  crc_acc;
   logic [7:0]  msb_seen;
   logic [7:0]  lsb_seen;
   logic [47:0] words_so_far;
   logic        frame_good;

   task automatic report(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ b[i];
         c  = {c[6:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic int frame_words(input logic [1:0] kind);
      case (kind)
         KIND_VERSION:  return 1;
         KIND_SERIAL:   return 3;
         default:       return 2;
      endcase
   endfunction

   // percent score in q8, rounded to nearest with halves away from zero
   function automatic logic [23:0] q8_score(input logic [15:0] w, input int offset,
                                            input int span);
      longint d;
      longint num;
      longint q;
      d   = (int'(w) > offset) ? longint'(int'(w) - offset) : 64'sd0;
      num = 64'sd25600 * (longint'(span) - d);
      if (num >= 0) begin
         q = (num + span / 2) / span;
      end else begin
         q = -((-num + span / 2) / span);
      end
      return q[23:0];
   endfunction

   function automatic void clear_frame();
      byte_pos     = 2'd0;
      word_count   = 2'd0;
      crc_acc      = CRC_INIT;
      words_so_far = '0;
      frame_good   = 1'b1;
   endfunction

   task automatic predict_beat(input logic [7:0] b, input logic fs);
      checked_word_type r;
      logic [15:0]      w;
      if (fs) begin
         clear_frame();
      end
      if (byte_pos == 2'd0) begin
         msb_seen = b;
         crc_acc  = crc_byte(crc_acc, b);
         byte_pos = 2'd1;
      end else if (byte_pos == 2'd1) begin
         lsb_seen = b;
         crc_acc  = crc_byte(crc_acc, b);
         byte_pos = 2'd2;
      end else begin
         w = {msb_seen, lsb_seen};
         r.word_value     = w;
         r.crc_ok         = (crc_acc == b);
         r.word_index     = word_count;
         r.frame_ok       = frame_good & r.crc_ok;
         r.last_word      = (int'(word_count) + 1 >= frame_words(kind_model));
         if (word_count < 2'd3) begin
            words_so_far = words_so_far | (48'(w) << (16 * int'(word_count)));
         end
         r.combined_value = (r.last_word && kind_model != KIND_MEASUREMENT) ?
                            words_so_far : 48'd0;
         r.air_quality    = 24'd0;
         if (kind_model == KIND_MEASUREMENT) begin
            if (word_count == 2'd0) begin
               r.air_quality = q8_score(w, int'(CO2_OFFSET), int'(CO2_SPAN));
            end else if (word_count == 2'd1) begin
               r.air_quality = q8_score(w, int'(VOC_OFFSET), int'(VOC_SPAN));
            end
         end
         expected_words.push_back(r);
         if (r.last_word) begin
            clear_frame();
         end else begin
            frame_good = r.frame_ok;
            word_count = word_count + 2'd1;
            byte_pos   = 2'd0;
            crc_acc    = CRC_INIT;
         end
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_beat(req_data_byte, req_frame_start);
            beats_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (beat_queue.size() > 0) begin
               sensor_beat_type nb;
               nb = beat_queue.pop_front();
               req_valid       <= 1'b1;
               req_data_byte   <= nb.data;
               req_frame_start <= nb.start;
               send_gap = (idle_on && $urandom_range(0, 99) < 30) ? idle_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report($sformatf("result beat with nothing expected, word %h", rsp_word_value));
            end else begin
               got_expected = expected_words.pop_front();
               if (rsp_word_value !== got_expected.word_value)
                  report($sformatf("word_value got %h exp %h",
                                   rsp_word_value, got_expected.word_value));
               if (rsp_crc_ok !== got_expected.crc_ok)
                  report($sformatf("crc_ok got %b exp %b (word %h)",
                                   rsp_crc_ok, got_expected.crc_ok, got_expected.word_value));
               if (rsp_word_index !== got_expected.word_index)
                  report($sformatf("word_index got %0d exp %0d",
                                   rsp_word_index, got_expected.word_index));
               if (rsp_last_word !== got_expected.last_word)
                  report($sformatf("last_word got %b exp %b",
                                   rsp_last_word, got_expected.last_word));
               if (rsp_frame_ok !== got_expected.frame_ok)
                  report($sformatf("frame_ok got %b exp %b",
                                   rsp_frame_ok, got_expected.frame_ok));
               if (rsp_combined_value !== got_expected.combined_value)
                  report($sformatf("combined_value got %h exp %h",
                                   rsp_combined_value, got_expected.combined_value));
               if (rsp_air_quality !== got_expected.air_quality)
                  report($sformatf("air_quality got %0d exp %0d (word %h idx %0d)",
                                   rsp_air_quality, $signed(got_expected.air_quality),
                                   got_expected.word_value, got_expected.word_index));
            end
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 25) begin
               recv_stall = idle_gap();
            end
         end
      end
   end

   // long receiver hold-off while the sender keeps offering beats
   initial begin
      wait (beats_accepted >= HOLD_AT_BEAT);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic push_beat(input logic [7:0] data, input logic start);
      sensor_beat_type nb;
      nb.data  = data;
      nb.start = start;
      beat_queue.push_back(nb);
      items_pushed++;
   endtask

   task automatic push_word(input logic [15:0] w, input logic start, input bit bad_crc);
      logic [7:0] c;
      c = crc_byte(crc_byte(CRC_INIT, w[15:8]), w[7:0]);
      if (bad_crc) begin
         c = c ^ 8'($urandom_range(1, 255));
      end
      push_beat(w[15:8], start);
      push_beat(w[7:0], 1'b0);
      push_beat(c, 1'b0);
   endtask

   // biased toward the score knees and the word extremes
   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom_range(0, 700));
         1:       return 16'($urandom_range(4000, 5600));
         2:       return 16'($urandom_range(0, 400));
         3:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic push_frame(input int nw, input bit start, input int bad_pct);
      for (int i = 0; i < nw; i++) begin
         push_word(rand_word(), start && (i == 0), $urandom_range(0, 99) < bad_pct);
      end
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (beat_queue.size() != 0 || req_valid || expected_words.size() != 0);
      // beats without a result may still be inside the block
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_kind(input logic [1:0] kind);
      wait_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= kind;
      @(posedge clock);
      csr_we    <= 1'b0;
      kind_model = kind;
      @(negedge clock);
   endtask

   task automatic random_phase(input int n_items);
      int stop_at;
      int sel;
      stop_at = items_pushed + n_items;
      while (items_pushed < stop_at) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            push_frame(frame_words(kind_model), $urandom_range(0, 3) != 0, 15);
         end else if (sel < 82) begin
            push_frame($urandom_range(1, 3), 1'b1, 20);
         end else if (sel < 92) begin
            // cut-off frame; what follows restarts it only if it carries a frame start
            repeat ($urandom_range(1, 2)) push_beat(8'($urandom()), $urandom_range(0, 1));
         end else begin
            repeat ($urandom_range(1, 4)) push_beat(8'($urandom()), $urandom_range(0, 3) == 0);
         end
      end
   endtask

   initial begin
      logic [1:0] phase_kind;
      clear_frame();
      msb_seen = 8'h00;
      lsb_seen = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // measurement kind out of reset: score extremes, bad crc on second word
      push_word(16'h0000, 1'b1, 1'b0);
      push_word(16'hFFFF, 1'b0, 1'b1);
      // new frame with no frame start
      push_word(16'hFFFF, 1'b0, 1'b0);
      push_word(16'd50, 1'b0, 1'b0);

      set_kind(KIND_SERIAL);
      push_word(16'h1234, 1'b1, 1'b1);
      push_word(16'hABCD, 1'b0, 1'b0);
      // kind drops to one word while two words are held
      set_kind(KIND_VERSION);
      push_word(16'h00FF, 1'b0, 1'b0);
      // stray msb, then a frame start takes over
      push_beat(8'hA5, 1'b0);
      push_word(16'h8001, 1'b1, 1'b0);

      for (int p = 0; p < 8; p++) begin
         phase_kind = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
         set_kind(phase_kind);
         idle_on = (p != 4);
         random_phase(PHASE_ITEMS);
      end

      wait_idle();
      if (expected_words.size() != 0) begin
         report($sformatf("%0d expected results never arrived", expected_words.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
